/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of this project.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on aclk, skipped while aresetn is low
`define MPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Assertion on aclk that also holds through reset
`define MPD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* hw/rtl/mpd_pkg.sv */
// Shared types, constants and the Morse lookup for the pulse decoder.
// No dependencies.
package mpd_pkg;

    localparam int TICK_BITS_DEF = 16;
    localparam int CFG_W         = 16;
    localparam int CHAR_W        = 7;
    localparam int CNT_W         = 3;
    localparam int PAT_W         = 5;
    localparam int CFG_IDX_W     = 2;

    typedef logic [CFG_W-1:0]     cfg_word_t;
    typedef logic [CHAR_W-1:0]    char_t;
    typedef logic [CNT_W-1:0]     sym_count_t;
    typedef logic [PAT_W-1:0]     sym_pattern_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Register indexes
    localparam cfg_idx_t REG_MIN_PULSE  = 2'd0;
    localparam cfg_idx_t REG_DASH       = 2'd1;
    localparam cfg_idx_t REG_LETTER_GAP = 2'd2;

    // Register reset values
    localparam cfg_word_t MIN_PULSE_RST  = 16'd30;
    localparam cfg_word_t DASH_RST       = 16'd400;
    localparam cfg_word_t LETTER_GAP_RST = 16'd600;

    // Symbol counter limits
    localparam sym_count_t SYM_MAX_STORED = 3'd5;
    localparam sym_count_t SYM_OVERFLOW   = 3'd6;

    localparam char_t CODE_UNKNOWN = 7'd63;

    // Decode a held symbol sequence; first symbol is MSB, 1 = dash
    function automatic char_t morse_lookup(sym_count_t count, sym_pattern_t pattern);
        char_t c;
        c = CODE_UNKNOWN;
        case (count)
            3'd1: begin
                c = pattern[0] ? 7'("T") : 7'("E");
            end
            3'd2: begin
                case (pattern[1:0])
                    2'b00:   c = 7'("I");
                    2'b01:   c = 7'("A");
                    2'b10:   c = 7'("N");
                    default: c = 7'("M");
                endcase
            end
            3'd3: begin
                case (pattern[2:0])
                    3'b000:  c = 7'("S");
                    3'b001:  c = 7'("U");
                    3'b010:  c = 7'("R");
                    3'b011:  c = 7'("W");
                    3'b100:  c = 7'("D");
                    3'b101:  c = 7'("K");
                    3'b110:  c = 7'("G");
                    default: c = 7'("O");
                endcase
            end
            3'd4: begin
                case (pattern[3:0])
                    4'b0000: c = 7'("H");
                    4'b0001: c = 7'("V");
                    4'b0010: c = 7'("F");
                    4'b0100: c = 7'("L");
                    4'b0110: c = 7'("P");
                    4'b0111: c = 7'("J");
                    4'b1000: c = 7'("B");
                    4'b1001: c = 7'("X");
                    4'b1010: c = 7'("C");
                    4'b1011: c = 7'("Y");
                    4'b1100: c = 7'("Z");
                    4'b1101: c = 7'("Q");
                    default: c = CODE_UNKNOWN;
                endcase
            end
            3'd5: begin
                case (pattern)
                    5'b01111: c = 7'("1");
                    5'b00111: c = 7'("2");
                    5'b00011: c = 7'("3");
                    5'b00001: c = 7'("4");
                    5'b00000: c = 7'("5");
                    5'b10000: c = 7'("6");
                    5'b11000: c = 7'("7");
                    5'b11100: c = 7'("8");
                    5'b11110: c = 7'("9");
                    5'b11111: c = 7'("0");
                    default:  c = CODE_UNKNOWN;
                endcase
            end
            default: c = CODE_UNKNOWN;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/morse_pulse_decoder.sv */
// A sample taken into the sample register is processed into the result register, which drives m_*.
// Throughput: one line sample per cycle while m_* is not stalled; the sample and result registers
// form two stages, so one more sample is taken while a finished character waits on m_ready.
// Reset (aresetn low, synchronous): pulse/gap timers, symbols and both stages clear,
// configuration registers return to 30 / 400 / 600. No clearing pass is needed.
// Top level of the Morse pulse decoder; depends on mpd_pkg.
module morse_pulse_decoder #(
    parameter int TICK_COUNTER_BITS = mpd_pkg::TICK_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // line samples
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_line_level,
    // decoded characters
    output logic                  m_valid,
    input  logic                  m_ready,
    output mpd_pkg::char_t        m_char_code,
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  mpd_pkg::cfg_idx_t     cfg_index,
    input  mpd_pkg::cfg_word_t    cfg_data
);
    import mpd_pkg::*;

    localparam int TW    = TICK_COUNTER_BITS;
    localparam int CMP_W = (TW > CFG_W) ? TW : CFG_W;

    typedef logic [TW-1:0] tick_t;

    // configuration
    cfg_word_t min_pulse_reg, dash_reg, letter_gap_reg;

    // input stage
    logic in_valid_reg;
    logic in_level_reg;

    // decoder state
    logic         prev_level_reg, prev_level_next;
    tick_t        high_ticks_reg, high_ticks_next;
    tick_t        gap_ticks_reg, gap_ticks_next;
    sym_count_t   sym_count_reg, sym_count_next;
    sym_pattern_t sym_pattern_reg, sym_pattern_next;

    // result stage
    logic  out_valid_reg, out_valid_next;
    char_t out_char_reg, out_char_next;

    logic         advance;
    logic         falling, long_pulse, is_dash, emit;
    sym_count_t   cnt_app;
    sym_pattern_t pat_app;

    assign cfg_ready   = 1'b1;
    assign m_valid     = out_valid_reg;
    assign m_char_code = out_char_reg;

    // the sample in the input stage is processed once the result stage can take it
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // pulse classification on a falling edge
    assign falling    = !in_level_reg && prev_level_reg;
    assign long_pulse = CMP_W'(high_ticks_reg) > CMP_W'(min_pulse_reg);
    assign is_dash    = !(CMP_W'(high_ticks_reg) < CMP_W'(dash_reg));

    always_comb begin
        prev_level_next  = prev_level_reg;
        high_ticks_next  = high_ticks_reg;
        gap_ticks_next   = gap_ticks_reg;
        cnt_app          = sym_count_reg;
        pat_app          = sym_pattern_reg;
        emit             = 1'b0;
        sym_count_next   = sym_count_reg;
        sym_pattern_next = sym_pattern_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        out_char_next    = out_char_reg;

        if (advance) begin
            prev_level_next = in_level_reg;
            if (in_level_reg) begin
                // high: time the pulse
                if (!prev_level_reg) begin
                    high_ticks_next = TW'(1);
                end else if (high_ticks_reg != '1) begin
                    high_ticks_next = high_ticks_reg + 1'b1;
                end
            end else begin
                // low: restart or advance the gap timer
                if (falling) begin
                    gap_ticks_next = '0;
                    if (long_pulse) begin
                        if (sym_count_reg < SYM_MAX_STORED) begin
                            pat_app = {sym_pattern_reg[PAT_W-2:0], is_dash};
                            cnt_app = sym_count_reg + 1'b1;
                        end else begin
                            cnt_app = SYM_OVERFLOW;
                        end
                    end
                end else if (gap_ticks_reg != '1) begin
                    gap_ticks_next = gap_ticks_reg + 1'b1;
                end

                // letter gap reached: decode held symbols
                emit = (cnt_app != '0) &&
                       (CMP_W'(gap_ticks_next) > CMP_W'(letter_gap_reg));
            end

            if (emit) begin
                sym_count_next   = '0;
                sym_pattern_next = '0;
                out_valid_next   = 1'b1;
                out_char_next    = morse_lookup(cnt_app, pat_app);
            end else begin
                sym_count_next   = cnt_app;
                sym_pattern_next = pat_app;
            end
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_pulse_reg   <= MIN_PULSE_RST;
            dash_reg        <= DASH_RST;
            letter_gap_reg  <= LETTER_GAP_RST;
            in_valid_reg    <= 1'b0;
            prev_level_reg  <= 1'b0;
            high_ticks_reg  <= '0;
            gap_ticks_reg   <= '0;
            sym_count_reg   <= '0;
            sym_pattern_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MIN_PULSE:  min_pulse_reg  <= cfg_data;
                    REG_DASH:       dash_reg       <= cfg_data;
                    REG_LETTER_GAP: letter_gap_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            prev_level_reg  <= prev_level_next;
            high_ticks_reg  <= high_ticks_next;
            gap_ticks_reg   <= gap_ticks_next;
            sym_count_reg   <= sym_count_next;
            sym_pattern_reg <= sym_pattern_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_level_reg <= s_line_level;
        end
        out_char_reg <= out_char_next;
    end

endmodule

/* hw/rtl/mpd_check.sv */
// Port-level checker for the Morse pulse decoder, bound to the top level.
// Depends on mpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mpd_check (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               s_line_level,
    input logic               m_valid,
    input logic               m_ready,
    input mpd_pkg::char_t     m_char_code
);
    import mpd_pkg::*;

    logic code_legal;
    logic s_take;
    assign code_legal = (m_char_code >= 7'("0") && m_char_code <= 7'("9")) ||
                        (m_char_code >= 7'("A") && m_char_code <= 7'("Z")) ||
                        (m_char_code == CODE_UNKNOWN);
    assign s_take = s_valid && s_ready;

    // a stalled character holds
    `MPD_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_char_code),
                "character changed under stall")
    // only letters, digits or the unknown mark come out
    `MPD_ASSERT(a_code_legal, m_valid |-> code_legal, "illegal character code")
    // a new character follows an accepted low sample
    `MPD_ASSERT(a_out_cause, $rose(m_valid) |-> $past(s_take, 2) && !$past(s_line_level, 2),
                "character without a low sample")
    // nothing is pending after reset
    `MPD_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind morse_pulse_decoder mpd_check u_mpd_check (.*);
